>>> rtl/unsigned_decimal_field_formatter_defines.svh
// ----------------------------------------------------------------------------
// Unsigned decimal field formatter: assertion macros
// Shared property wrappers used by the formatter top level.
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_DECIMAL_FIELD_FORMATTER_DEFINES_SVH
`define UNSIGNED_DECIMAL_FIELD_FORMATTER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define UDFF_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define UDFF_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("%m: next-cycle check failed");

`endif

>>> rtl/udff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udff_pkg
// Widths, character codes and shared types of the decimal field formatter.
// ----------------------------------------------------------------------------
package udff_pkg;

    // Field and value sizes
    localparam int VALUE_BITS = 32;
    localparam int MAX_FIELD  = 60;
    localparam int FLD_W      = 6;
    localparam int CHAR_W     = 6;
    localparam int TOTAL_W    = 32;

    // Decimal digits needed for the largest value: floor(bits * log10(2)) + 1
    localparam int NDIG       = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_W      = NDIG * 4;
    localparam int DIG_W      = $clog2(NDIG + 1);
    localparam int DIG_IDX_W  = $clog2(NDIG);
    localparam int FIELD_CW   = $clog2(MAX_FIELD + 1);
    localparam int LEN_W      = (FIELD_CW > DIG_W) ? FIELD_CW : DIG_W;
    localparam int BIT_CNT_W  = $clog2(VALUE_BITS + 1);

    // Character codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CH_SPACE = CHAR_W'(32);

    typedef logic [NDIG-1:0][3:0] t_bcd;

    // Character plan handed from the sizing stage to the emitter
    typedef struct packed {
        logic [LEN_W-1:0] pad;
        logic [LEN_W-1:0] zeros;
        logic [DIG_W-1:0] digits;
        logic [LEN_W-1:0] total;
        logic             left;
        logic             pad_zero;
    } t_plan;

    typedef struct packed {
        logic busy;
        logic done;
    } t_b2b_stat;

    typedef struct packed {
        logic busy;
    } t_emit_stat;

    // Clamp a width or precision field at MAX_FIELD
    function automatic logic [LEN_W-1:0] sat_field(input logic [FLD_W-1:0] f);
        if (int'(f) > MAX_FIELD) begin
            return LEN_W'(MAX_FIELD);
        end
        return LEN_W'(f);
    endfunction

endpackage

>>> rtl/udff_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udff_in_if / udff_out_if
// Valid/ready channels for conversion requests and emitted characters.
// ----------------------------------------------------------------------------
interface udff_in_if import udff_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic [FLD_W-1:0]      field_width;
    logic                  precision_given;
    logic [FLD_W-1:0]      min_digits;
    logic                  left_justify;
    logic                  zero_pad;

    modport source (
        output valid, value, field_width, precision_given, min_digits,
               left_justify, zero_pad,
        input  ready
    );
    modport sink (
        input  valid, value, field_width, precision_given, min_digits,
               left_justify, zero_pad,
        output ready
    );
endinterface

interface udff_out_if import udff_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  out_char;
    logic               last_char;
    logic [TOTAL_W-1:0] total_written;

    modport source (
        output valid, out_char, last_char, total_written,
        input  ready
    );
    modport sink (
        input  valid, out_char, last_char, total_written,
        output ready
    );
endinterface

>>> rtl/udff_bin2bcd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udff_bin2bcd
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// ----------------------------------------------------------------------------
module udff_bin2bcd import udff_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_value,
    output t_b2b_stat             o_stat,
    output t_bcd                  o_bcd
);

    logic [VALUE_BITS-1:0] r_bin;
    t_bcd                  r_bcd;
    logic [BIT_CNT_W-1:0]  r_cnt;
    logic                  r_done;

    logic [VALUE_BITS-1:0] n_bin;
    t_bcd                  n_bcd;
    logic [BIT_CNT_W-1:0]  n_cnt;
    logic                  n_done;
    t_bcd                  adj;
    logic [BCD_W-1:0]      adj_flat;

    // Add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            adj[i] = (r_bcd[i] >= 4'd5) ? (r_bcd[i] + 4'd3) : r_bcd[i];
        end
        adj_flat = adj;
    end

    // Start loads the value; each step moves one bit into the BCD register
    always_comb begin
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_bin = i_value;
            n_bcd = '0;
            n_cnt = BIT_CNT_W'(VALUE_BITS);
        end else if (r_cnt != '0) begin
            n_bin  = {r_bin[VALUE_BITS-2:0], 1'b0};
            n_bcd  = t_bcd'({adj_flat[BCD_W-2:0], r_bin[VALUE_BITS-1]});
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == BIT_CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;
    assign o_bcd       = r_bcd;

endmodule

>>> rtl/udff_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udff_emitter
// Steps through leading pad, zeros, digits and trailing pad into an output
// register, one character per cycle unless stalled; keeps a running character count.
// ----------------------------------------------------------------------------
module udff_emitter import udff_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_plan             i_plan,
    input  t_bcd              i_bcd,
    output t_emit_stat        o_stat,
    udff_out_if.source        o_rsp
);

    logic [LEN_W-1:0]   r_pad;
    logic [LEN_W-1:0]   r_zeros;
    logic [DIG_W-1:0]   r_digits;
    logic [LEN_W-1:0]   r_rem;
    logic               r_left;
    logic               r_pad_zero;
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;
    logic [TOTAL_W-1:0] r_total;
    logic [TOTAL_W-1:0] r_count;

    logic [LEN_W-1:0]   n_pad;
    logic [LEN_W-1:0]   n_zeros;
    logic [DIG_W-1:0]   n_digits;
    logic [CHAR_W-1:0]  n_char;
    logic [DIG_IDX_W-1:0] dig_idx;
    logic               can_load;
    logic               fire;

    assign can_load = !r_out_valid || o_rsp.ready;
    assign fire     = (r_rem != '0) && can_load;
    assign dig_idx  = DIG_IDX_W'(r_digits - 1'b1);

    // Pick the next character: leading pad, zeros, digits, trailing pad
    always_comb begin
        n_pad    = r_pad;
        n_zeros  = r_zeros;
        n_digits = r_digits;
        n_char   = CH_SPACE;
        if (!r_left && r_pad != '0) begin
            n_char = r_pad_zero ? CH_ZERO : CH_SPACE;
            n_pad  = r_pad - 1'b1;
        end else if (r_zeros != '0) begin
            n_char  = CH_ZERO;
            n_zeros = r_zeros - 1'b1;
        end else if (r_digits != '0) begin
            n_char   = CH_ZERO + CHAR_W'(i_bcd[dig_idx]);
            n_digits = r_digits - 1'b1;
        end else begin
            n_char = CH_SPACE;
            n_pad  = r_pad - 1'b1;
        end
    end

    // Hold the plan counters; advance one step per emitted character
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pad      <= i_plan.pad;
            r_zeros    <= i_plan.zeros;
            r_digits   <= i_plan.digits;
            r_left     <= i_plan.left;
            r_pad_zero <= i_plan.pad_zero;
        end else if (fire) begin
            r_pad    <= n_pad;
            r_zeros  <= n_zeros;
            r_digits <= n_digits;
        end
        if (fire) begin
            r_char  <= n_char;
            r_last  <= (r_rem == LEN_W'(1));
            r_total <= r_count + 1'b1;
        end
    end

    // Control: remaining count, output valid, running total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= '0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (i_load) begin
                r_rem <= i_plan.total;
            end else if (fire) begin
                r_rem <= r_rem - 1'b1;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
                r_count     <= r_count + 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.busy         = (r_rem != '0);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.out_char      = r_char;
    assign o_rsp.last_char     = r_last;
    assign o_rsp.total_written = r_total;

endmodule

>>> rtl/unsigned_decimal_field_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsigned_decimal_field_formatter
// printf-style unsigned decimal conversion with width, precision and flags.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one conversion request: value, field width, precision
//   (with its enable), left-justify and zero-pad flags. o_rsp returns the
//   text one ASCII character per response, with last_char on the final one
//   and the running character count in total_written. A request can yield
//   no characters at all (value 0, precision 0, width 0).
//   A request passes through the bit-serial binary to BCD converter; the
//   state machine waits for the registered converter finish, the sizing
//   state plans the text, then the emitter sends one character per cycle
//   while the receiver takes them. i_req.ready stays low until the last
//   character is loaded, so a new request is not taken before the previous
//   one is through; the shift-and-add-3 loop and the single character
//   path set the request rate. i_req.ready is high only while no request is in work.
//   Reset clears the running count and drops any request in work.
//   When the receiver stalls, the character in the output register holds
//   and emission pauses; i_req.ready rises when the state register is back
//   in idle, after the previous request's last character enters the output register.
// ----------------------------------------------------------------------------
`include "unsigned_decimal_field_formatter_defines.svh"

module unsigned_decimal_field_formatter import udff_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    udff_in_if.sink    i_req,
    udff_out_if.source o_rsp
);

    localparam int         ST_W    = 2;
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SIZE = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [ST_W-1:0]  r_state;
    logic [ST_W-1:0]  n_state;
    logic [LEN_W-1:0] r_width;
    logic [LEN_W-1:0] r_prec;
    logic             r_prec_on;
    logic             r_left;
    logic             r_zpad;

    logic             accept;
    t_b2b_stat        b2b_stat;
    t_emit_stat       emit_stat;
    t_bcd             bcd;
    t_plan            plan;
    logic [DIG_W-1:0] nd;
    logic [LEN_W-1:0] body;

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);

    // Capture the formatting controls of a new request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_width   <= sat_field(i_req.field_width);
            r_prec    <= sat_field(i_req.min_digits);
            r_prec_on <= i_req.precision_given;
            r_left    <= i_req.left_justify;
            r_zpad    <= i_req.zero_pad;
        end
    end

    udff_bin2bcd u_b2b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_value (i_req.value),
        .o_stat  (b2b_stat),
        .o_bcd   (bcd)
    );

    // Size the text: significant digits, precision zeros and padding
    always_comb begin
        nd = '0;
        for (int i = 0; i < NDIG; i++) begin
            if (bcd[i] != 4'd0) begin
                nd = DIG_W'(i + 1);
            end
        end
        // A zero value prints one digit unless an explicit precision of 0
        if (nd == '0 && !(r_prec_on && r_prec == '0)) begin
            nd = DIG_W'(1);
        end
        body = (r_prec_on && r_prec > LEN_W'(nd)) ? r_prec : LEN_W'(nd);
        plan.pad      = (r_width > body) ? (r_width - body) : '0;
        plan.zeros    = body - LEN_W'(nd);
        plan.digits   = nd;
        plan.total    = (r_width > body) ? r_width : body;
        plan.left     = r_left;
        plan.pad_zero = r_zpad && !r_prec_on;
    end

    udff_emitter u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (r_state == ST_SIZE),
        .i_plan  (plan),
        .i_bcd   (bcd),
        .o_stat  (emit_stat),
        .o_rsp   (o_rsp)
    );

    // Sequence one request: convert, size, emit
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (b2b_stat.done) begin
                    n_state = ST_SIZE;
                end
            end
            ST_SIZE: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!emit_stat.busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A plan is loaded only into an emitter that has finished
    `UDFF_ASSERT_NOW(a_load_idle, i_clk, i_rst_n, r_state == ST_SIZE, !emit_stat.busy)
    // The converter rests while no request is in work
    `UDFF_ASSERT_NOW(a_conv_rest, i_clk, i_rst_n, r_state == ST_IDLE, !b2b_stat.busy)
    // A non-final character waiting on the output means the request is still emitting
    `UDFF_ASSERT_NOW(a_tail_pending, i_clk, i_rst_n, o_rsp.valid && !o_rsp.last_char,
        r_state == ST_EMIT)
    // The running count steps by one from each taken character to the next
    `UDFF_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, o_rsp.valid && o_rsp.ready,
        !o_rsp.valid || o_rsp.total_written == TOTAL_W'($past(o_rsp.total_written) + 1'b1))

endmodule
